// ===== hdl/psq_pkg.sv =====
`default_nettype none

package psq_pkg;

    localparam int unsigned LEVEL_W   = 10;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned DELTA_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [LEVEL_W-1:0] POWER_ON_THR_RST  = 10'd800;
    localparam logic [LEVEL_W-1:0] POWER_OFF_THR_RST = 10'd600;
    localparam logic [LEVEL_W-1:0] DCIN_THR_RST      = 10'd649;
    localparam logic [MS_W-1:0]    SHUTDOWN_TO_RST   = 16'd20000;
    localparam logic [MS_W-1:0]    OFF_TO_RST        = 16'd5000;
    localparam logic [MS_W-1:0]    REBOOT_TO_RST     = 16'd2000;

    localparam logic [CFG_IDX_W-1:0] REG_POWER_ON_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_OFF_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DCIN_THR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_TO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TO        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REBOOT_TO     = 3'd5;

    localparam logic [2:0] LED_NONE     = 3'd0;
    localparam logic [2:0] LED_CHARGING = 3'd1;
    localparam logic [2:0] LED_GOOD     = 3'd2;
    localparam logic [2:0] LED_DRAINING = 3'd3;
    localparam logic [2:0] LED_SHUTDOWN = 3'd4;
    localparam logic [2:0] LED_OFF      = 3'd5;
    localparam logic [2:0] LED_WATCHDOG = 3'd6;

    typedef enum logic [3:0] {
        ST_BEGIN          = 4'd0,
        ST_ENT_PON_OFF    = 4'd1,
        ST_PON_OFF        = 4'd2,
        ST_ENT_PON_ON     = 4'd3,
        ST_PON_ON         = 4'd4,
        ST_ENT_POFF_ON    = 4'd5,
        ST_POFF_ON        = 4'd6,
        ST_ENT_SHUT       = 4'd7,
        ST_SHUT           = 4'd8,
        ST_ENT_WDR        = 4'd9,
        ST_WDR            = 4'd10,
        ST_ENT_OFF        = 4'd11,
        ST_OFF            = 4'd12
    } psq_state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] power_on_threshold;
        logic [LEVEL_W-1:0] power_off_threshold;
        logic [LEVEL_W-1:0] dcin_threshold;
        logic [MS_W-1:0]    shutdown_timeout_ms;
        logic [MS_W-1:0]    off_timeout_ms;
        logic [MS_W-1:0]    reboot_timeout_ms;
    } psq_cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] dcin_level;
        logic [LEVEL_W-1:0] supercap_level;
        logic [LEVEL_W-1:0] supply_level;
        logic               shutdown_request;
        logic [MS_W-1:0]    watchdog_max;
        logic [MS_W-1:0]    watchdog_age;
        logic [DELTA_W-1:0] delta_ms;
    } psq_item_t;

    typedef struct packed {
        logic [3:0] current_state;
        logic       enable_5v;
        logic       limit_pin;
        logic       enin_drive;
        logic [2:0] led_pattern;
        logic       shutdown_ack;
        logic       watchdog_clear;
    } psq_result_t;

endpackage

`default_nettype wire

// ===== hdl/psq_cfg_regs.sv =====
`default_nettype none

module psq_cfg_regs
    import psq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    output psq_cfg_t                  cfg
);

    psq_cfg_t cfg_reg;
    psq_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POWER_ON_THR:  cfg_next.power_on_threshold  = cfg_data[LEVEL_W-1:0];
                REG_POWER_OFF_THR: cfg_next.power_off_threshold = cfg_data[LEVEL_W-1:0];
                REG_DCIN_THR:      cfg_next.dcin_threshold      = cfg_data[LEVEL_W-1:0];
                REG_SHUTDOWN_TO:   cfg_next.shutdown_timeout_ms = cfg_data[MS_W-1:0];
                REG_OFF_TO:        cfg_next.off_timeout_ms      = cfg_data[MS_W-1:0];
                REG_REBOOT_TO:     cfg_next.reboot_timeout_ms   = cfg_data[MS_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_on_threshold  <= POWER_ON_THR_RST;
            cfg_reg.power_off_threshold <= POWER_OFF_THR_RST;
            cfg_reg.dcin_threshold      <= DCIN_THR_RST;
            cfg_reg.shutdown_timeout_ms <= SHUTDOWN_TO_RST;
            cfg_reg.off_timeout_ms      <= OFF_TO_RST;
            cfg_reg.reboot_timeout_ms   <= REBOOT_TO_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/psq_fsm.sv =====
`default_nettype none

module psq_fsm
    import psq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire psq_item_t  item,
    input  wire psq_cfg_t   cfg,
    output psq_result_t     result
);

    psq_state_t      state_reg, state_next;
    logic [MS_W-1:0] timer_reg, timer_next;
    logic            en5v_reg, en5v_next;
    logic            lim_reg, lim_next;
    logic            enin_reg, enin_next;
    logic [2:0]      led;
    logic            sack;
    logic            wclr;
    logic            timer_clr;

    logic [MS_W:0]   timer_sum;
    logic [MS_W-1:0] timer_sat;
    logic            wd_expired;

    // saturating timer gain, taken before the state decisions
    assign timer_sum  = {1'b0, timer_reg} + {{(MS_W+1-DELTA_W){1'b0}}, item.delta_ms};
    assign timer_sat  = timer_sum[MS_W] ? {MS_W{1'b1}} : timer_sum[MS_W-1:0];
    assign wd_expired = (item.watchdog_max != '0) && (item.watchdog_age > item.watchdog_max);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_BEGIN:
                state_next = (item.supply_level < cfg.power_on_threshold) ?
                             ST_ENT_PON_OFF : ST_ENT_PON_ON;
            ST_ENT_PON_OFF:
                state_next = ST_PON_OFF;
            ST_PON_OFF:
            begin
                if (item.dcin_level > cfg.power_on_threshold)
                    state_next = ST_ENT_PON_ON;
                else if (item.dcin_level < cfg.dcin_threshold)
                    state_next = ST_ENT_OFF;
            end
            ST_ENT_PON_ON:
                state_next = ST_PON_ON;
            ST_PON_ON:
            begin
                if (wd_expired)
                    state_next = ST_ENT_WDR;
                else if (item.dcin_level < cfg.dcin_threshold)
                    state_next = ST_ENT_POFF_ON;
            end
            ST_ENT_POFF_ON:
                state_next = ST_POFF_ON;
            ST_POFF_ON:
            begin
                if (wd_expired)
                    state_next = ST_ENT_WDR;
                else if (item.shutdown_request)
                    state_next = ST_ENT_SHUT;
                else if (item.dcin_level > cfg.dcin_threshold)
                    state_next = ST_ENT_PON_ON;
                else if (item.supercap_level < cfg.power_off_threshold)
                    state_next = ST_ENT_OFF;
            end
            ST_ENT_SHUT:
                state_next = ST_SHUT;
            ST_SHUT:
            begin
                if (timer_sat > cfg.shutdown_timeout_ms)
                    state_next = ST_ENT_OFF;
            end
            ST_ENT_WDR:
                state_next = ST_WDR;
            ST_WDR:
            begin
                if (timer_sat > cfg.reboot_timeout_ms)
                    state_next = ST_BEGIN;
            end
            ST_ENT_OFF:
                state_next = ST_OFF;
            ST_OFF:
            begin
                if (timer_sat > cfg.off_timeout_ms)
                    state_next = ST_BEGIN;
            end
            default:
                state_next = ST_BEGIN;
        endcase
    end

    always_comb
    begin
        en5v_next = en5v_reg;
        lim_next  = lim_reg;
        enin_next = enin_reg;
        led       = LED_NONE;
        sack      = 1'b0;
        wclr      = 1'b0;
        timer_clr = 1'b0;
        unique case (state_reg)
            ST_BEGIN:
            begin
                en5v_next = 1'b0;
                lim_next  = 1'b1;
                enin_next = 1'b0;
                wclr      = 1'b1;
            end
            ST_ENT_PON_OFF:
                led = LED_CHARGING;
            ST_ENT_PON_ON:
            begin
                en5v_next = 1'b1;
                led       = LED_GOOD;
            end
            ST_ENT_POFF_ON:
                led = LED_DRAINING;
            ST_POFF_ON:
                sack = !wd_expired && item.shutdown_request;
            ST_ENT_SHUT:
            begin
                led       = LED_SHUTDOWN;
                timer_clr = 1'b1;
            end
            ST_ENT_WDR:
            begin
                en5v_next = 1'b0;
                led       = LED_WATCHDOG;
                timer_clr = 1'b1;
            end
            ST_ENT_OFF:
            begin
                en5v_next = 1'b0;
                enin_next = 1'b1;
                lim_next  = 1'b0;
                led       = LED_OFF;
                timer_clr = 1'b1;
            end
            default:
                led = LED_NONE;
        endcase
        timer_next = timer_clr ? '0 : timer_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BEGIN;
            timer_reg <= '0;
            en5v_reg  <= 1'b0;
            lim_reg   <= 1'b1;
            enin_reg  <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            timer_reg <= timer_next;
            en5v_reg  <= en5v_next;
            lim_reg   <= lim_next;
            enin_reg  <= enin_next;
        end
    end

    always_comb
    begin
        result.current_state  = 4'(state_next);
        result.enable_5v      = en5v_next;
        result.limit_pin      = lim_next;
        result.enin_drive     = enin_next;
        result.led_pattern    = led;
        result.shutdown_ack   = sack;
        result.watchdog_clear = wclr;
    end

endmodule

`default_nettype wire

// ===== hdl/supercap_power_sequencer_unit.sv =====
// Path: an accepted word goes into the input register, and its result into the result register,
// which it enters only when the result register is free or being drained.
// Throughput: one word per cycle while the output is not stalled; the sequencer state, timer
// and pin levels update as a word moves from the input register into the result register.
// Reset (rst_n, async, active low): sequencer in BEGIN, timer zero, 5 V off,
// limit pin high, enable-in released, thresholds and timeouts to defaults, both stages empty.
`default_nettype none

module supercap_power_sequencer_unit
    import psq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [LEVEL_W-1:0]   dcin_level,
    input  wire logic [LEVEL_W-1:0]   supercap_level,
    input  wire logic [LEVEL_W-1:0]   supply_level,
    input  wire logic                 shutdown_request,
    input  wire logic [MS_W-1:0]      watchdog_max,
    input  wire logic [MS_W-1:0]      watchdog_age,
    input  wire logic [DELTA_W-1:0]   delta_ms,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [3:0]                current_state,
    output logic                      enable_5v,
    output logic                      limit_pin,
    output logic                      enin_drive,
    output logic [2:0]                led_pattern,
    output logic                      shutdown_ack,
    output logic                      watchdog_clear
);

    psq_cfg_t    cfg;
    psq_item_t   item_reg;
    logic        item_valid_reg;
    psq_result_t res_reg;
    psq_result_t res_next;
    logic        res_valid_reg;
    logic        advance;
    logic        in_fire;

    psq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // move a word forward when the result slot is free or being drained
    assign advance  = item_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.dcin_level       <= dcin_level;
            item_reg.supercap_level   <= supercap_level;
            item_reg.supply_level     <= supply_level;
            item_reg.shutdown_request <= shutdown_request;
            item_reg.watchdog_max     <= watchdog_max;
            item_reg.watchdog_age     <= watchdog_age;
            item_reg.delta_ms         <= delta_ms;
        end
    end

    psq_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = res_valid_reg;
    assign current_state  = res_reg.current_state;
    assign enable_5v      = res_reg.enable_5v;
    assign limit_pin      = res_reg.limit_pin;
    assign enin_drive     = res_reg.enin_drive;
    assign led_pattern    = res_reg.led_pattern;
    assign shutdown_ack   = res_reg.shutdown_ack;
    assign watchdog_clear = res_reg.watchdog_clear;

endmodule

`default_nettype wire

// ===== verif/tb_supercap_power_sequencer_unit.sv =====
`default_nettype none

module tb_supercap_power_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import psq_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [LEVEL_W-1:0]   dcin_level = '0;
    logic [LEVEL_W-1:0]   supercap_level = '0;
    logic [LEVEL_W-1:0]   supply_level = '0;
    logic                 shutdown_request = 1'b0;
    logic [MS_W-1:0]      watchdog_max = '0;
    logic [MS_W-1:0]      watchdog_age = '0;
    logic [DELTA_W-1:0]   delta_ms = '0;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [3:0]           current_state;
    logic                 enable_5v;
    logic                 limit_pin;
    logic                 enin_drive;
    logic [2:0]           led_pattern;
    logic                 shutdown_ack;
    logic                 watchdog_clear;

    supercap_power_sequencer_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .dcin_level       (dcin_level),
        .supercap_level   (supercap_level),
        .supply_level     (supply_level),
        .shutdown_request (shutdown_request),
        .watchdog_max     (watchdog_max),
        .watchdog_age     (watchdog_age),
        .delta_ms         (delta_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .current_state    (current_state),
        .enable_5v        (enable_5v),
        .limit_pin        (limit_pin),
        .enin_drive       (enin_drive),
        .led_pattern      (led_pattern),
        .shutdown_ack     (shutdown_ack),
        .watchdog_clear   (watchdog_clear)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sequencer shadow: registers, state, timer and pin levels
    psq_cfg_t    cfg_shadow;
    psq_state_t  seq_st;
    logic [15:0] ms_count;
    logic        pin_5v;
    logic        pin_lim;
    logic        pin_enin;

    psq_item_t   step_words_q[$];
    psq_result_t predicted_q[$];
    psq_item_t   in_word;
    psq_result_t got;
    psq_result_t want;

    int unsigned sent_cnt = 0;
    int unsigned got_cnt = 0;
    int unsigned fail_cnt = 0;
    int unsigned cfg_cnt = 0;
    logic [15:0] seen_states = '0;

    int          in_idle_max = 13;
    int          out_idle_max = 13;
    int          in_wait = 0;
    bit          in_armed = 1'b0;
    int          out_wait = 0;
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;

    // Random stream shaping: runs of coherent supply conditions
    int          run_left = 0;
    int          dc_mode = 0;
    int          wd_mode = 0;
    int          sreq_pct = 0;
    bit          long_deltas = 1'b0;

    function automatic bit wd_tripped(logic [15:0] lim, logic [15:0] age);
        return (lim != 16'd0) && (age > lim);
    endfunction

    function automatic psq_result_t sequencer_step(psq_item_t it);
        psq_result_t r;
        logic [16:0] t;
        r = '0;
        t = {1'b0, ms_count} + {9'd0, it.delta_ms};
        ms_count = t[16] ? 16'hFFFF : t[15:0];
        case (seq_st)
            ST_BEGIN:
            begin
                pin_5v = 1'b0;
                pin_lim = 1'b1;
                pin_enin = 1'b0;
                r.watchdog_clear = 1'b1;
                if (it.supply_level < cfg_shadow.power_on_threshold)
                    seq_st = ST_ENT_PON_OFF;
                else
                    seq_st = ST_ENT_PON_ON;
            end
            ST_ENT_PON_OFF:
            begin
                r.led_pattern = LED_CHARGING;
                seq_st = ST_PON_OFF;
            end
            ST_PON_OFF:
            begin
                if (it.dcin_level > cfg_shadow.power_on_threshold)
                    seq_st = ST_ENT_PON_ON;
                else if (it.dcin_level < cfg_shadow.dcin_threshold)
                    seq_st = ST_ENT_OFF;
            end
            ST_ENT_PON_ON:
            begin
                pin_5v = 1'b1;
                r.led_pattern = LED_GOOD;
                seq_st = ST_PON_ON;
            end
            ST_PON_ON:
            begin
                if (wd_tripped(it.watchdog_max, it.watchdog_age))
                    seq_st = ST_ENT_WDR;
                else if (it.dcin_level < cfg_shadow.dcin_threshold)
                    seq_st = ST_ENT_POFF_ON;
            end
            ST_ENT_POFF_ON:
            begin
                r.led_pattern = LED_DRAINING;
                seq_st = ST_POFF_ON;
            end
            ST_POFF_ON:
            begin
                // watchdog beats a pending shutdown, which then stays unacknowledged
                if (wd_tripped(it.watchdog_max, it.watchdog_age))
                    seq_st = ST_ENT_WDR;
                else if (it.shutdown_request)
                begin
                    r.shutdown_ack = 1'b1;
                    seq_st = ST_ENT_SHUT;
                end
                else if (it.dcin_level > cfg_shadow.dcin_threshold)
                    seq_st = ST_ENT_PON_ON;
                else if (it.supercap_level < cfg_shadow.power_off_threshold)
                    seq_st = ST_ENT_OFF;
            end
            ST_ENT_SHUT:
            begin
                r.led_pattern = LED_SHUTDOWN;
                ms_count = 16'd0;
                seq_st = ST_SHUT;
            end
            ST_SHUT:
            begin
                if (ms_count > cfg_shadow.shutdown_timeout_ms)
                    seq_st = ST_ENT_OFF;
            end
            ST_ENT_WDR:
            begin
                ms_count = 16'd0;
                pin_5v = 1'b0;
                r.led_pattern = LED_WATCHDOG;
                seq_st = ST_WDR;
            end
            ST_WDR:
            begin
                if (ms_count > cfg_shadow.reboot_timeout_ms)
                    seq_st = ST_BEGIN;
            end
            ST_ENT_OFF:
            begin
                pin_5v = 1'b0;
                pin_enin = 1'b1;
                pin_lim = 1'b0;
                r.led_pattern = LED_OFF;
                ms_count = 16'd0;
                seq_st = ST_OFF;
            end
            ST_OFF:
            begin
                if (ms_count > cfg_shadow.off_timeout_ms)
                    seq_st = ST_BEGIN;
            end
            default:
                seq_st = ST_BEGIN;
        endcase
        r.current_state = seq_st;
        r.enable_5v = pin_5v;
        r.limit_pin = pin_lim;
        r.enin_drive = pin_enin;
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] level_around(int centre, int spread);
        int v;
        v = centre - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v[LEVEL_W-1:0];
    endfunction

    function automatic psq_item_t make_item();
        psq_item_t it;
        int        pon;
        int        dthr;
        int        poff;
        int        lo;
        int        hi;
        int        wmax;
        int        roll;
        pon  = int'(cfg_shadow.power_on_threshold);
        dthr = int'(cfg_shadow.dcin_threshold);
        poff = int'(cfg_shadow.power_off_threshold);
        if (run_left == 0)
        begin
            run_left = $urandom_range(6, 40);
            dc_mode  = $urandom_range(0, 3);
            wd_mode  = $urandom_range(0, 2);
            sreq_pct = $urandom_range(0, 40);
        end
        run_left--;

        // plain noise now and then
        if ($urandom_range(0, 99) < 12)
        begin
            it.dcin_level       = 10'($urandom_range(0, 1023));
            it.supercap_level   = 10'($urandom_range(0, 1023));
            it.supply_level     = 10'($urandom_range(0, 1023));
            it.shutdown_request = 1'($urandom_range(0, 1));
            it.watchdog_max     = 16'($urandom_range(0, 65535));
            it.watchdog_age     = 16'($urandom_range(0, 65535));
            it.delta_ms         = 8'($urandom_range(0, 255));
            return it;
        end

        case (dc_mode)
            0: it.dcin_level = level_around(pon + 60, 60);
            1:
            begin
                lo = (dthr < pon) ? dthr : pon;
                hi = (dthr < pon) ? pon : dthr;
                it.dcin_level = level_around((lo + hi) / 2, (hi - lo) / 2 + 2);
            end
            2: it.dcin_level = level_around(dthr - 60, 60);
            default: it.dcin_level = level_around($urandom_range(0, 1) ? pon : dthr, 3);
        endcase

        if ($urandom_range(0, 99) < 85)
            it.supercap_level = level_around(poff + 150, 150);
        else
            it.supercap_level = level_around(poff, 4);
        if ($urandom_range(0, 1))
            it.supply_level = level_around(pon, 3);
        else
            it.supply_level = 10'($urandom_range(0, 1023));

        it.shutdown_request = ($urandom_range(0, 99) < sreq_pct);

        case (wd_mode)
            0:
            begin
                wmax = 0;
                it.watchdog_age = 16'($urandom_range(0, 65535));
            end
            1:
            begin
                wmax = $urandom_range(1, 65535);
                if ($urandom_range(0, 99) < 6 && wmax < 65535)
                    it.watchdog_age = 16'($urandom_range(wmax + 1, 65535));
                else
                    it.watchdog_age = 16'($urandom_range(0, wmax));
            end
            default:
            begin
                wmax = $urandom_range(1, 1000);
                it.watchdog_age = 16'(wmax - 1 + int'($urandom_range(0, 2)));
            end
        endcase
        it.watchdog_max = 16'(wmax);

        roll = $urandom_range(0, 99);
        if (long_deltas && roll < 70)
            it.delta_ms = 8'($urandom_range(200, 255));
        else if (roll < 55)
            it.delta_ms = 8'($urandom_range(0, 30));
        else if (roll < 85)
            it.delta_ms = 8'($urandom_range(0, 255));
        else if (roll < 93)
            it.delta_ms = 8'd255;
        else
            it.delta_ms = 8'd0;
        return it;
    endfunction

    function automatic logic [MS_W-1:0] rand_timeout();
        if ($urandom_range(0, 99) < 85)
            return 16'($urandom_range(0, 800));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_POWER_ON_THR:  cfg_shadow.power_on_threshold  = val[LEVEL_W-1:0];
            REG_POWER_OFF_THR: cfg_shadow.power_off_threshold = val[LEVEL_W-1:0];
            REG_DCIN_THR:      cfg_shadow.dcin_threshold      = val[LEVEL_W-1:0];
            REG_SHUTDOWN_TO:   cfg_shadow.shutdown_timeout_ms = val;
            REG_OFF_TO:        cfg_shadow.off_timeout_ms      = val;
            REG_REBOOT_TO:     cfg_shadow.reboot_timeout_ms   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_cfg(psq_cfg_t c);
        logic [31:0] junk;
        junk = $urandom;
        // upper data bits of the level registers must be dropped
        write_reg(REG_POWER_ON_THR,  {junk[5:0], c.power_on_threshold});
        write_reg(REG_POWER_OFF_THR, {junk[11:6], c.power_off_threshold});
        write_reg(REG_DCIN_THR,      {junk[17:12], c.dcin_threshold});
        write_reg(REG_SHUTDOWN_TO,   c.shutdown_timeout_ms);
        write_reg(REG_OFF_TO,        c.off_timeout_ms);
        write_reg(REG_REBOOT_TO,     c.reboot_timeout_ms);
        cfg_cnt++;
    endtask

    task automatic push_word(psq_item_t it);
        step_words_q.push_back(it);
        sent_cnt++;
    endtask

    task automatic push_step(int dc, int sc, int sup, int sreq, int wmax, int wage, int dms);
        psq_item_t it;
        it.dcin_level       = 10'(dc);
        it.supercap_level   = 10'(sc);
        it.supply_level     = 10'(sup);
        it.shutdown_request = 1'(sreq);
        it.watchdog_max     = 16'(wmax);
        it.watchdog_age     = 16'(wage);
        it.delta_ms         = 8'(dms);
        push_word(it);
    endtask

    task automatic wait_drained();
        wait (got_cnt >= sent_cnt);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_random(int n, int imax, int omax);
        in_idle_max  = imax;
        out_idle_max = omax;
        repeat (n)
            push_word(make_item());
        wait_drained();
    endtask

    // Input side: draw a gap before each word, hold valid until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (!in_armed && step_words_q.size() != 0)
                begin
                    in_wait  = $urandom_range(0, in_idle_max);
                    in_armed = 1'b1;
                end
                if (in_armed && in_wait == 0)
                begin
                    in_word  = step_words_q.pop_front();
                    in_armed = 1'b0;
                    dcin_level       <= in_word.dcin_level;
                    supercap_level   <= in_word.supercap_level;
                    supply_level     <= in_word.supply_level;
                    shutdown_request <= in_word.shutdown_request;
                    watchdog_max     <= in_word.watchdog_max;
                    watchdog_age     <= in_word.watchdog_age;
                    delta_ms         <= in_word.delta_ms;
                    in_valid         <= 1'b1;
                end
                else
                begin
                    if (in_armed)
                        in_wait--;
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: stall a random number of cycles after each taken word
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                out_wait = $urandom_range(0, out_idle_max);
            if (out_wait > 0)
            begin
                out_ready <= 1'b0;
                out_wait--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end
        else
        begin
            in_taken  <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;
            if (in_valid && in_ready)
                predicted_q.push_back(sequencer_step(in_word));
            if (out_valid && out_ready)
            begin
                got = '{current_state, enable_5v, limit_pin, enin_drive,
                        led_pattern, shutdown_ack, watchdog_clear};
                seen_states[got.current_state] = 1'b1;
                got_cnt++;
                if (predicted_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("ERROR: result word %0d arrived with none predicted, state=%0d",
                                 got_cnt, got.current_state);
                end
                else
                begin
                    want = predicted_q.pop_front();
                    if (got.current_state !== want.current_state ||
                        got.enable_5v !== want.enable_5v ||
                        got.limit_pin !== want.limit_pin ||
                        got.enin_drive !== want.enin_drive ||
                        got.led_pattern !== want.led_pattern ||
                        got.shutdown_ack !== want.shutdown_ack ||
                        got.watchdog_clear !== want.watchdog_clear)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                        begin
                            $display("ERROR: word %0d expected st=%0d 5v=%b lim=%b enin=%b %s",
                                     got_cnt, want.current_state, want.enable_5v,
                                     want.limit_pin, want.enin_drive, "");
                            $display("       expected led=%0d ack=%b wclr=%b",
                                     want.led_pattern, want.shutdown_ack,
                                     want.watchdog_clear);
                            $display("       got st=%0d 5v=%b lim=%b enin=%b led=%0d ack=%b wclr=%b",
                                     got.current_state, got.enable_5v, got.limit_pin,
                                     got.enin_drive, got.led_pattern, got.shutdown_ack,
                                     got.watchdog_clear);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("Timeout waiting for result words");
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        psq_cfg_t c;
        int       k;

        cfg_shadow = '{POWER_ON_THR_RST, POWER_OFF_THR_RST, DCIN_THR_RST,
                       SHUTDOWN_TO_RST, OFF_TO_RST, REBOOT_TO_RST};
        seq_st   = ST_BEGIN;
        ms_count = 16'd0;
        pin_5v   = 1'b0;
        pin_lim  = 1'b1;
        pin_enin = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed walk through every state, default thresholds, short timeouts
        write_reg(REG_SHUTDOWN_TO, 16'd100);
        write_reg(REG_OFF_TO, 16'd100);
        write_reg(REG_REBOOT_TO, 16'd100);
        in_idle_max  = 13;
        out_idle_max = 13;
        push_step(1023, 1023, 1023, 1, 65535, 65535, 255);
        push_step(0, 0, 0, 0, 0, 0, 0);
        push_step(700, 700, 900, 0, 100, 100, 10);   // age equal to limit: no trip
        push_step(700, 700, 900, 0, 100, 101, 10);
        push_step(700, 700, 900, 0, 0, 0, 50);
        push_step(700, 700, 900, 0, 0, 0, 100);      // timer equal to timeout: hold
        push_step(700, 700, 900, 0, 0, 0, 1);
        push_step(700, 700, 799, 0, 0, 0, 10);
        push_step(700, 700, 900, 0, 0, 0, 10);
        push_step(800, 700, 900, 0, 0, 0, 10);
        push_step(801, 700, 900, 0, 0, 0, 10);
        push_step(700, 700, 900, 0, 0, 0, 10);
        push_step(648, 700, 900, 0, 0, 65535, 10);   // watchdog disabled
        push_step(700, 700, 900, 0, 0, 0, 10);
        push_step(649, 600, 900, 0, 0, 0, 10);
        push_step(600, 700, 900, 1, 5, 6, 10);       // watchdog and shutdown together
        push_step(600, 700, 900, 0, 0, 0, 10);
        push_step(600, 700, 900, 0, 0, 0, 255);
        push_step(700, 700, 800, 0, 0, 0, 10);
        push_step(700, 700, 900, 0, 0, 0, 10);
        push_step(0, 700, 900, 0, 0, 0, 10);
        push_step(600, 700, 900, 0, 0, 0, 10);
        push_step(600, 700, 900, 1, 0, 0, 10);
        push_step(600, 700, 900, 0, 0, 0, 10);
        push_step(600, 700, 900, 0, 5, 6, 255);      // shutdown ignores watchdog
        push_step(600, 700, 900, 0, 0, 0, 10);
        push_step(600, 700, 900, 0, 0, 0, 255);
        push_step(700, 700, 0, 0, 0, 0, 10);
        wait_drained();

        // defaults again with short timeouts; unused register indexes
        c = '{10'd800, 10'd600, 10'd649, 16'd250, 16'd400, 16'd150};
        apply_cfg(c);
        write_reg(3'd6, 16'h0005);
        write_reg(3'd7, 16'hFFFF);
        run_random(300, 13, 13);

        // everything at zero, no idling
        apply_cfg('0);
        run_random(150, 0, 0);

        // everything at maximum: timeouts never expire, timer saturates
        c = '{10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        apply_cfg(c);
        long_deltas = 1'b1;
        run_random(250, 13, 13);
        long_deltas = 1'b0;

        for (k = 0; k < 4; k++)
        begin
            c.power_on_threshold  = 10'($urandom_range(0, 1023));
            c.power_off_threshold = 10'($urandom_range(0, 1023));
            c.dcin_threshold      = 10'($urandom_range(0, 1023));
            c.shutdown_timeout_ms = rand_timeout();
            c.off_timeout_ms      = rand_timeout();
            c.reboot_timeout_ms   = rand_timeout();
            apply_cfg(c);
            case (k)
                0: run_random(190, 13, 13);
                1: run_random(190, 0, 13);
                2: run_random(190, 13, 0);
                default: run_random(190, 3, 3);
            endcase
        end

        $display("Checked %0d of %0d steps across %0d register settings, %0d mismatches",
                 got_cnt, sent_cnt, cfg_cnt + 1, fail_cnt);
        $display("Sequencer states reached: %b (bit per state code)", seen_states);
        if (fail_cnt == 0 && predicted_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/psq_pkg.sv
hdl/psq_cfg_regs.sv
hdl/psq_fsm.sv
hdl/supercap_power_sequencer_unit.sv
verif/tb_supercap_power_sequencer_unit.sv
